[src/fsbr_pkg.sv]
package fsbr_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_status;

    // result field widths and limits
    localparam int RUN_BITS = 31;
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};
    localparam int MAX_RUNS = 46;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] LAST_RUN_IDX = CNT_W'(MAX_RUNS - 1);

    // sign codes
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    // branch codes
    localparam logic DIR_L = 1'b0;
    localparam logic DIR_R = 1'b1;

endpackage

[src/fsbr_div.sv]
module fsbr_div #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output logic [W-1:0]         o_quot,
    output logic [W-1:0]         o_rem,
    output fsbr_pkg::t_div_status o_status
);

    localparam int CW = $clog2(W + 1);

    logic [W:0]    r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]    w_shift;
    logic [W+1:0]  w_diff;
    logic          w_fits;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        w_shift = {r_rem[W-1:0], r_quo[W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
        w_fits  = ~w_diff[W+1];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[W:0] : w_shift;
            r_quo <= {r_quo[W-2:0], w_fits};
        end
    end

    assign o_quot            = r_quo;
    assign o_rem             = r_rem[W-1:0];
    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem[W-1:0] == '0);

endmodule

[src/fraction_to_stern_brocot_runs_core.sv]
// channel  | direction | handshake                 | beat contents
// ---------+-----------+---------------------------+-------------------------------------
// command  | in        | start high while busy low | i_numerator, i_denominator
// result   | out       | o_valid, one cycle        | o_value_sign, o_direction,
//          |           |                           | o_run_length, o_last_run, o_bad_input
//
// zero denominator, zero numerator and values of magnitude one give their single beat in the
// cycle after start, with busy staying low.
// every other fraction is split into runs; for each run the sequencer loads the
// shared restoring divider, waits for the division, then emits the run.
// at most 46 runs per item; busy is high throughout. synchronous active-low
// reset returns the sequencer to idle.
// the receiver cannot stall: each result beat is shown for exactly one cycle.
module fraction_to_stern_brocot_runs_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [31:0]                   i_numerator,
    input  logic signed [31:0]                   i_denominator,
    output logic                                 o_valid,
    output logic signed [1:0]                    o_value_sign,
    output logic                                 o_direction,
    output logic [fsbr_pkg::RUN_BITS-1:0]        o_run_length,
    output logic                                 o_last_run,
    output logic                                 o_bad_input
);

    localparam int VB    = VALUE_BITS;
    localparam int LEN_W = (VB > fsbr_pkg::RUN_BITS) ? VB : fsbr_pkg::RUN_BITS;

    fsbr_pkg::t_state r_state, n_state;

    logic [VB-1:0]              r_a;
    logic [VB-1:0]              r_b;
    logic                       r_dir;
    logic signed [1:0]          r_sign;
    logic [fsbr_pkg::CNT_W-1:0] r_cnt;

    // operand decode
    logic [VB+31:0] w_num_ext, w_den_ext;
    logic [VB-1:0]  w_num_raw, w_den_raw;
    logic [VB-1:0]  w_num_mag, w_den_mag;
    logic           w_num_neg, w_den_neg;
    logic           w_num_zero, w_den_zero;
    logic           w_special;
    logic signed [1:0] w_sign;

    // sequencer controls
    logic w_accept;
    logic w_div_start;
    logic w_emit;
    logic w_last;

    // divider
    logic [VB-1:0]          w_dividend, w_divisor;
    logic [VB-1:0]          w_quot, w_rem;
    fsbr_pkg::t_div_status  w_div;

    // run length
    logic [VB-1:0]                 w_len;
    logic [LEN_W-1:0]              w_len_ext;
    logic [fsbr_pkg::RUN_BITS-1:0] w_len_sat;

    // narrow or zero-extend inputs to VALUE_BITS and take sign and magnitude
    always_comb begin
        w_num_ext  = {{VB{1'b0}}, i_numerator};
        w_den_ext  = {{VB{1'b0}}, i_denominator};
        w_num_raw  = w_num_ext[VB-1:0];
        w_den_raw  = w_den_ext[VB-1:0];
        w_num_neg  = w_num_raw[VB-1];
        w_den_neg  = w_den_raw[VB-1];
        w_num_mag  = w_num_neg ? (~w_num_raw + VB'(1)) : w_num_raw;
        w_den_mag  = w_den_neg ? (~w_den_raw + VB'(1)) : w_den_raw;
        w_num_zero = (w_num_raw == '0);
        w_den_zero = (w_den_raw == '0);
        if (w_num_zero || w_den_zero) begin
            w_sign = fsbr_pkg::SIGN_ZERO;
        end else if (w_num_neg ^ w_den_neg) begin
            w_sign = fsbr_pkg::SIGN_NEG;
        end else begin
            w_sign = fsbr_pkg::SIGN_POS;
        end
        w_special = w_num_zero || w_den_zero || (w_num_mag == w_den_mag);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsbr_pkg::ST_IDLE: begin
                if (start && !w_special) begin
                    n_state = fsbr_pkg::ST_LOAD;
                end
            end
            fsbr_pkg::ST_LOAD: begin
                n_state = fsbr_pkg::ST_WAIT;
            end
            fsbr_pkg::ST_WAIT: begin
                if (w_div.done) begin
                    n_state = w_last ? fsbr_pkg::ST_IDLE : fsbr_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = fsbr_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_accept    = 1'b0;
        w_div_start = 1'b0;
        w_emit      = 1'b0;
        busy        = 1'b1;
        unique case (r_state)
            fsbr_pkg::ST_IDLE: begin
                busy     = 1'b0;
                w_accept = start;
            end
            fsbr_pkg::ST_LOAD: begin
                w_div_start = 1'b1;
            end
            fsbr_pkg::ST_WAIT: begin
                w_emit = w_div.done;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // larger magnitude is divided by the smaller one
    assign w_dividend = r_dir ? r_a : r_b;
    assign w_divisor  = r_dir ? r_b : r_a;

    fsbr_div #(
        .W(VB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_rem      (w_rem),
        .o_status   (w_div)
    );

    // run length: an exact division ends the path one step early
    always_comb begin
        w_len     = w_div.rem_zero ? (w_quot - VB'(1)) : w_quot;
        w_len_ext = LEN_W'(w_len);
        w_len_sat = (w_len_ext > LEN_W'(fsbr_pkg::RUN_MAX)) ?
                    fsbr_pkg::RUN_MAX : w_len_ext[fsbr_pkg::RUN_BITS-1:0];
        w_last    = w_div.rem_zero || (r_cnt == fsbr_pkg::LAST_RUN_IDX);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsbr_pkg::ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (w_accept && w_special) || w_emit;
        end
    end

    // operand and run registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a    <= w_num_mag;
            r_b    <= w_den_mag;
            r_dir  <= (w_num_mag < w_den_mag) ? fsbr_pkg::DIR_L : fsbr_pkg::DIR_R;
            r_sign <= w_sign;
            r_cnt  <= '0;
        end else if (w_emit) begin
            if (r_dir == fsbr_pkg::DIR_L) begin
                r_b <= w_div.rem_zero ? r_a : w_rem;
            end else begin
                r_a <= w_div.rem_zero ? r_b : w_rem;
            end
            r_dir <= ~r_dir;
            r_cnt <= r_cnt + fsbr_pkg::CNT_W'(1);
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (w_accept && w_special) begin
            o_value_sign <= w_den_zero ? fsbr_pkg::SIGN_ZERO : w_sign;
            o_direction  <= fsbr_pkg::DIR_L;
            o_run_length <= '0;
            o_last_run   <= 1'b1;
            o_bad_input  <= w_den_zero;
        end else if (w_emit) begin
            o_value_sign <= r_sign;
            o_direction  <= r_dir;
            o_run_length <= w_len_sat;
            o_last_run   <= w_last;
            o_bad_input  <= 1'b0;
        end
    end

    // divider finishes only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == fsbr_pkg::ST_WAIT))
        else $error("divider finished outside the wait state");

    // an accepted command always leads to a busy sequencer or an immediate beat
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted command produced no work");

    // an error beat is always the only beat of its item
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_input) |-> (o_last_run && o_run_length == '0))
        else $error("error beat not a lone last beat");

    // an empty run only appears as the single beat of its item
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_length == '0) |-> o_last_run)
        else $error("empty run in the middle of a path");

    // the sequencer returns to idle right after the last beat is produced
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> !busy)
        else $error("sequencer busy after last run");

endmodule
